// ----- sv/mer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, register map, sequencer states and the structs passed between the
// register file, the sequencer and the pixel emitter.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_W  = 10;              // config coordinate and radius width
    localparam int PIX_W    = 12;              // output pixel coordinate width
    localparam int X_W      = COORD_W + 1;     // current point x
    localparam int Y_W      = COORD_W + 2;     // current point y, signed
    localparam int SQ_W     = 2 * COORD_W;     // squared radius
    localparam int DEC_W    = 48;              // decision value, scaled by four
    localparam int SLOPE_W  = SQ_W + X_W + 3;  // slope terms, signed
    localparam int MUL_W    = 25;              // multiplier operand, signed
    localparam int PROD_W   = 2 * MUL_W;       // multiplier product
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS_X,
        REG_RADIUS_Y
    } mer_reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_PP,
        QUAD_NP,
        QUAD_PN,
        QUAD_NN
    } mer_quad_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_LOAD_RY,
        ST_INIT,
        ST_CHECK,
        ST_RC_AA,
        ST_RC_M1,
        ST_RC_BB,
        ST_RC_M2,
        ST_RC_M3,
        ST_R1_X,
        ST_R1_DX,
        ST_R1_DY,
        ST_R2_STEP,
        ST_R2_DY,
        ST_EMIT
    } mer_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] radius_x;
        logic [COORD_W-1:0] radius_y;
    } mer_cfg_t;

    typedef struct packed {
        logic                  valid;
        logic [X_W-1:0]        x;
        logic signed [Y_W-1:0] y;
        logic                  fin;
    } mer_grp_t;

endpackage

// ----- sv/midpoint_ellipse_rasterizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks an axis-aligned ellipse with the midpoint method and streams each
// visited point as four mirrored pixels.
// ----------------------------------------------------------------------------
// Each request on the input stream runs one midpoint iteration: s_tdata[0]
// set starts a new ellipse from the center and radius registers, clear
// advances the one in progress (and produces nothing when no ellipse is
// active). An iteration sends four pixels, quadrants 0 to 3, with tlast on
// the fourth and tuser on all four of the group that finishes the ellipse.
// All products go through one registered multiplier under a sequencer: it
// squares both radii, sets up the walk on a start, runs the region change
// when it falls due, computes the step, then holds the group for the four
// output transfers, which wait on m_tready; s_tready stays low until the
// last pixel of the group has been taken. Registers are read live on every
// request.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core import mer_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] start_req
    // pixel stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [11:0] pixel_x, [23:12] pixel_y, [25:24] quadrant
    output logic                m_tlast,   // last_of_group
    output logic                m_tuser    // [0] final_group
);

    mer_cfg_t cfg;
    mer_grp_t grp;
    logic     grp_done;

    mer_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mer_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .start_req  (s_tdata[0]),
        .item_ready (s_tready),
        .cfg        (cfg),
        .grp        (grp),
        .grp_done   (grp_done)
    );

    mer_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp      (grp),
        .center_x (cfg.center_x),
        .center_y (cfg.center_y),
        .grp_done (grp_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sv/mer_apb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// APB slave holding the ellipse center and semi-axes. Zero wait states.
// ----------------------------------------------------------------------------
module mer_apb_regs import mer_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output mer_cfg_t          cfg
);

    mer_cfg_t     cfg_reg, cfg_next;
    mer_reg_idx_t idx;
    logic         wr_en;

    assign idx    = mer_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_CENTER_X: cfg_next.center_x = pwdata[COORD_W-1:0];
                REG_CENTER_Y: cfg_next.center_y = pwdata[COORD_W-1:0];
                REG_RADIUS_X: cfg_next.radius_x = pwdata[COORD_W-1:0];
                REG_RADIUS_Y: cfg_next.radius_y = pwdata[COORD_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CENTER_X: prdata = APB_DW'(cfg_reg.center_x);
            REG_CENTER_Y: prdata = APB_DW'(cfg_reg.center_y);
            REG_RADIUS_X: prdata = APB_DW'(cfg_reg.radius_x);
            REG_RADIUS_Y: prdata = APB_DW'(cfg_reg.radius_y);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/mer_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module mer_mult import mer_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/mer_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint sequencer
// Holds the walk state and steps one midpoint iteration per request, using
// the shared multiplier for squares, slope terms and the region change.
// ----------------------------------------------------------------------------
module mer_seq import mer_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     item_valid,
    input  logic     start_req,
    output logic     item_ready,
    input  mer_cfg_t cfg,
    output mer_grp_t grp,
    input  logic     grp_done
);

    mer_state_t state_reg, state_next;

    logic                      busy_reg, busy_next;
    logic                      start_pend_reg, start_pend_next;
    logic                      r2_reg, r2_next;
    logic                      fin_reg, fin_next;
    logic [X_W-1:0]            cur_x_reg, cur_x_next;
    logic signed [Y_W-1:0]     cur_y_reg, cur_y_next;
    logic [X_W-1:0]            ex_reg, ex_next;
    logic signed [Y_W-1:0]     ey_reg, ey_next;
    logic signed [DEC_W-1:0]   dec_reg, dec_next;
    logic signed [SLOPE_W-1:0] sdx_reg, sdx_next;
    logic signed [SLOPE_W-1:0] sdy_reg, sdy_next;
    logic [SQ_W-1:0]           rx2_reg, rx2_next;
    logic [SQ_W-1:0]           ry2_reg, ry2_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [X_W-1:0]            x_inc;
    logic signed [Y_W-1:0]     y_dec;
    logic signed [MUL_W-1:0]   rx_m, ry_m, rx2_m, ry2_m, prod_m, x_inc_m, y_dec_m, odd_m;
    logic signed [DEC_W-1:0]   prod_d, rx2_d, ry2_d, sdx_d, dprod_d, sdx_n_d, sdy_n_d;
    logic signed [SLOPE_W-1:0] dprod_s, rx2_s, ry2_s, sdx_n, sdy_n;
    logic                      enter_r2;

    mer_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign x_inc    = cur_x_reg + X_W'(1);
    assign y_dec    = cur_y_reg - signed'(Y_W'(1));
    assign rx_m     = signed'(MUL_W'(cfg.radius_x));
    assign ry_m     = signed'(MUL_W'(cfg.radius_y));
    assign rx2_m    = signed'(MUL_W'(rx2_reg));
    assign ry2_m    = signed'(MUL_W'(ry2_reg));
    assign prod_m   = prod[MUL_W-1:0];
    assign x_inc_m  = signed'(MUL_W'(x_inc));
    assign y_dec_m  = MUL_W'(y_dec);
    assign odd_m    = signed'(MUL_W'({cur_x_reg, 1'b1}));

    assign prod_d   = prod[DEC_W-1:0];
    assign dprod_s  = signed'({prod[SLOPE_W-2:0], 1'b0});
    assign dprod_d  = DEC_W'(dprod_s);
    assign rx2_d    = signed'(DEC_W'(rx2_reg));
    assign ry2_d    = signed'(DEC_W'(ry2_reg));
    assign rx2_s    = signed'(SLOPE_W'(rx2_reg));
    assign ry2_s    = signed'(SLOPE_W'(ry2_reg));
    assign sdx_d    = DEC_W'(sdx_reg);
    assign sdx_n    = sdx_reg + (ry2_s <<< 1);
    assign sdy_n    = sdy_reg - (rx2_s <<< 1);
    assign sdx_n_d  = DEC_W'(sdx_n);
    assign sdy_n_d  = DEC_W'(sdy_n);
    assign enter_r2 = !r2_reg && !(sdx_reg < sdy_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid && (start_req || busy_reg)) begin
                    state_next = ST_SQ_RX;
                end
            end
            ST_SQ_RX:   state_next = ST_SQ_RY;
            ST_SQ_RY:   state_next = ST_LOAD_RY;
            ST_LOAD_RY: state_next = start_pend_reg ? ST_INIT : ST_CHECK;
            ST_INIT:    state_next = ST_CHECK;
            ST_CHECK: begin
                priority if (enter_r2) begin
                    state_next = ST_RC_AA;
                end else if (r2_reg) begin
                    state_next = ST_R2_STEP;
                end else begin
                    state_next = ST_R1_X;
                end
            end
            ST_RC_AA:   state_next = ST_RC_M1;
            ST_RC_M1:   state_next = ST_RC_BB;
            ST_RC_BB:   state_next = ST_RC_M2;
            ST_RC_M2:   state_next = ST_RC_M3;
            ST_RC_M3:   state_next = ST_R2_STEP;
            ST_R1_X:    state_next = ST_R1_DX;
            ST_R1_DX:   state_next = (dec_reg < 0) ? ST_EMIT : ST_R1_DY;
            ST_R1_DY:   state_next = ST_EMIT;
            ST_R2_STEP: state_next = (dec_reg > 0) ? ST_R2_DY : ST_EMIT;
            ST_R2_DY:   state_next = ST_EMIT;
            ST_EMIT:    state_next = grp_done ? ST_IDLE : ST_EMIT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        item_ready = (state_reg == ST_IDLE);
        grp.valid  = (state_reg == ST_EMIT);
        grp.x      = ex_reg;
        grp.y      = ey_reg;
        grp.fin    = fin_reg;
    end

    // datapath and multiplier operand select
    always_comb begin
        busy_next       = busy_reg;
        start_pend_next = start_pend_reg;
        r2_next         = r2_reg;
        fin_next        = fin_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        dec_next        = dec_reg;
        sdx_next        = sdx_reg;
        sdy_next        = sdy_reg;
        rx2_next        = rx2_reg;
        ry2_next        = ry2_reg;
        mul_a           = '0;
        mul_b           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    start_pend_next = start_req;
                    if (start_req) begin
                        busy_next = 1'b1;
                    end
                end
            end
            ST_SQ_RX: begin
                mul_a = rx_m;
                mul_b = rx_m;
            end
            ST_SQ_RY: begin
                rx2_next = prod[SQ_W-1:0];
                mul_a    = ry_m;
                mul_b    = ry_m;
            end
            ST_LOAD_RY: begin
                ry2_next = prod[SQ_W-1:0];
                mul_a    = rx2_m;
                mul_b    = ry_m;
            end
            ST_INIT: begin
                cur_x_next = '0;
                cur_y_next = signed'(Y_W'(cfg.radius_y));
                dec_next   = (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
                sdx_next   = '0;
                sdy_next   = dprod_s;
                r2_next    = 1'b0;
            end
            ST_CHECK: begin
                if (enter_r2) begin
                    r2_next = 1'b1;
                    mul_a   = odd_m;
                    mul_b   = odd_m;
                end
            end
            ST_RC_AA: begin
                mul_a = ry2_m;
                mul_b = prod_m;
            end
            ST_RC_M1: begin
                dec_next = prod_d;
                mul_a    = y_dec_m;
                mul_b    = y_dec_m;
            end
            ST_RC_BB: begin
                mul_a = rx2_m;
                mul_b = prod_m;
            end
            ST_RC_M2: begin
                dec_next = dec_reg + (prod_d <<< 2);
                mul_a    = rx2_m;
                mul_b    = ry2_m;
            end
            ST_RC_M3: begin
                dec_next = dec_reg - (prod_d <<< 2);
            end
            ST_R1_X: begin
                ex_next    = cur_x_reg;
                ey_next    = cur_y_reg;
                fin_next   = 1'b0;
                cur_x_next = x_inc;
                mul_a      = ry2_m;
                mul_b      = x_inc_m;
            end
            ST_R1_DX: begin
                sdx_next = dprod_s;
                if (dec_reg < 0) begin
                    dec_next = dec_reg + ((dprod_d + ry2_d) <<< 2);
                end else begin
                    cur_y_next = y_dec;
                    mul_a      = rx2_m;
                    mul_b      = y_dec_m;
                end
            end
            ST_R1_DY: begin
                sdy_next = dprod_s;
                dec_next = dec_reg + ((sdx_d - dprod_d + ry2_d) <<< 2);
            end
            ST_R2_STEP: begin
                ex_next    = cur_x_reg;
                ey_next    = cur_y_reg;
                cur_y_next = y_dec;
                // stepping below the y = 0 row ends the ellipse
                fin_next   = (cur_y_reg == 0);
                if (cur_y_reg == 0) begin
                    busy_next = 1'b0;
                end
                if (dec_reg > 0) begin
                    mul_a = rx2_m;
                    mul_b = y_dec_m;
                end else begin
                    cur_x_next = x_inc;
                    sdx_next   = sdx_n;
                    sdy_next   = sdy_n;
                    dec_next   = dec_reg + ((sdx_n_d - sdy_n_d + rx2_d) <<< 2);
                end
            end
            ST_R2_DY: begin
                sdy_next = dprod_s;
                dec_next = dec_reg + ((rx2_d - dprod_d) <<< 2);
            end
            ST_EMIT: begin
                start_pend_next = 1'b0;
            end
            default: begin
                busy_next = busy_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= 1'b0;
            start_pend_reg <= 1'b0;
            r2_reg         <= 1'b0;
            fin_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            start_pend_reg <= start_pend_next;
            r2_reg         <= r2_next;
            fin_reg        <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        dec_reg   <= dec_next;
        sdx_reg   <= sdx_next;
        sdy_reg   <= sdy_next;
        rx2_reg   <= rx2_next;
        ry2_reg   <= ry2_next;
    end

`ifndef SYNTH
    a_fin_in_r2: assert property (@(posedge aclk) disable iff (!aresetn)
        grp.valid && grp.fin |-> r2_reg)
        else $error("final group outside region two");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_done && fin_reg |=> !busy_reg)
        else $error("still busy after final group");

    a_r2_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(r2_reg) |-> $past(state_reg) == ST_CHECK)
        else $error("region two entered outside region check");

    a_idle_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && !busy_reg |-> fin_reg)
        else $error("busy dropped without final group");
`endif

endmodule

// ----- sv/mer_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel emitter
// Mirrors the current point into four pixels around the center and sends
// them on the result stream, one quadrant per transfer.
// ----------------------------------------------------------------------------
module mer_emit import mer_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  mer_grp_t            grp,
    input  logic [COORD_W-1:0]  center_x,
    input  logic [COORD_W-1:0]  center_y,
    output logic                grp_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    mer_quad_t        q_reg, q_next;
    logic             xfer;
    logic [PIX_W-1:0] cx, cy, ox, oy, pix_x, pix_y;

    assign xfer     = grp.valid && m_tready;
    assign grp_done = xfer && (q_reg == QUAD_NN);
    assign q_next   = xfer ? mer_quad_t'(q_reg + 2'd1) : q_reg;

    assign cx    = PIX_W'(center_x);
    assign cy    = PIX_W'(center_y);
    assign ox    = PIX_W'(grp.x);
    assign oy    = PIX_W'(grp.y);
    // quadrant bit 0 mirrors x, bit 1 mirrors y
    assign pix_x = q_reg[0] ? cx - ox : cx + ox;
    assign pix_y = q_reg[1] ? cy - oy : cy + oy;

    assign m_tvalid = grp.valid;
    assign m_tdata  = M_DATA_W'({q_reg, pix_y, pix_x});
    assign m_tlast  = (q_reg == QUAD_NN);
    assign m_tuser  = grp.fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= QUAD_PP;
        end else begin
            q_reg <= q_next;
        end
    end

`ifndef SYNTH
    a_quad_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        !grp.valid |-> q_reg == QUAD_PP)
        else $error("quadrant counter not at rest between groups");
`endif

endmodule
